FILE: src/rdh_pkg.sv
package rdh_pkg;

    localparam int TIMER_WIDTH         = 16;
    localparam int MODE_DEBOUNCE_TICKS = 20;
    localparam int CFG_WIDTH           = 16;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int DIGIT_WIDTH         = 4;

    typedef logic [TIMER_WIDTH-1:0]     tmr_t;
    typedef logic [CFG_WIDTH-1:0]       cfg_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [DIGIT_WIDTH-1:0]     count_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_PULSE_DB     = 3'd0,
        CFG_DIAL_TIMEOUT = 3'd1,
        CFG_HOOK_DB      = 3'd2,
        CFG_BUTTON_DB    = 3'd3,
        CFG_USE_MODE     = 3'd4,
        CFG_MODE_LOW     = 3'd5
    } cfg_idx_t;

    localparam cfg_t   PULSE_DB_RESET     = 16'd15;
    localparam cfg_t   DIAL_TIMEOUT_RESET = 16'd2000;
    localparam cfg_t   HOOK_DB_RESET      = 16'd50;
    localparam cfg_t   BUTTON_DB_RESET    = 16'd50;
    localparam cfg_t   MODE_DB_LIMIT      = cfg_t'(MODE_DEBOUNCE_TICKS);
    localparam count_t COUNT_MAX          = 4'd15;
    localparam count_t DIGIT_MAX          = 4'd9;

    typedef struct packed {
        logic   digit_valid;
        count_t digit;
    } dial_out_t;

    typedef struct packed {
        logic change;
        logic level;
    } deb_out_t;

    // saturating tick counter
    function automatic tmr_t tmr_inc(tmr_t t);
        return (&t) ? t : t + tmr_t'(1);
    endfunction

    // strictly greater, both sides zero extended
    function automatic logic tmr_gt(tmr_t t, cfg_t thr);
        return 33'(t) > 33'(thr);
    endfunction

    function automatic count_t map_digit(count_t c);
        return (c > DIGIT_MAX) ? count_t'(0) : c;
    endfunction

endpackage

FILE: src/rdh_debounce.sv
module rdh_debounce (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              level,
    input  rdh_pkg::cfg_t     thr,
    output rdh_pkg::deb_out_t result
);
    import rdh_pkg::*;

    logic last_raw_reg;
    logic state_reg;
    tmr_t since_reg;
    logic state_next;
    tmr_t since_next;

    always_comb
    begin
        since_next   = (level != last_raw_reg) ? '0 : tmr_inc(since_reg);
        state_next   = state_reg;
        result.change = 1'b0;
        if (tmr_gt(since_next, thr) && (level != state_reg))
        begin
            state_next    = level;
            result.change = 1'b1;
        end
        result.level = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= 1'b0;
            state_reg    <= 1'b0;
            since_reg    <= '0;
        end
        else if (adv)
        begin
            last_raw_reg <= level;
            state_reg    <= state_next;
            since_reg    <= since_next;
        end
    end

`ifndef SYNTHESIS
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(state_reg))
        else $error("debounced state moved without a tick");
`endif

endmodule

FILE: src/rdh_dial.sv
module rdh_dial (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               pulse_level,
    input  logic               mode_level,
    input  rdh_pkg::cfg_t      pulse_db,
    input  rdh_pkg::cfg_t      dial_timeout,
    input  logic               use_mode,
    input  logic               mode_low,
    output rdh_pkg::dial_out_t result
);
    import rdh_pkg::*;

    logic   pulse_prev_reg;
    count_t count_reg;
    logic   dialing_reg;
    tmr_t   since_pulse_reg;
    tmr_t   since_restart_reg;
    logic   mode_last_reg;
    logic   mode_stable_reg;
    tmr_t   since_mode_reg;

    count_t count_next;
    logic   dialing_next;
    tmr_t   since_pulse_next;
    tmr_t   since_restart_next;
    logic   mode_last_next;
    logic   mode_stable_next;
    tmr_t   since_mode_next;
    logic   pulse_hit;
    logic   mode_raw;

    always_comb
    begin
        since_pulse_next   = tmr_inc(since_pulse_reg);
        since_restart_next = tmr_inc(since_restart_reg);
        since_mode_next    = tmr_inc(since_mode_reg);
        count_next         = count_reg;
        dialing_next       = dialing_reg;
        mode_last_next     = mode_last_reg;
        mode_stable_next   = mode_stable_reg;
        result.digit_valid = 1'b0;
        result.digit       = '0;

        pulse_hit = pulse_prev_reg && !pulse_level && tmr_gt(since_pulse_next, pulse_db);
        if (pulse_hit)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + count_t'(1);
            end
            since_pulse_next   = '0;
            since_restart_next = '0;
            dialing_next       = 1'b1;
        end

        mode_raw = mode_level ^ mode_low;
        if (use_mode)
        begin
            if (mode_raw != mode_last_reg)
            begin
                since_mode_next = '0;
                mode_last_next  = mode_raw;
            end
            if (tmr_gt(since_mode_next, MODE_DB_LIMIT))
            begin
                mode_stable_next = mode_raw;
            end
            if (mode_stable_next)
            begin
                dialing_next       = 1'b1;
                since_restart_next = '0;
            end
            else if (dialing_next)
            begin
                // release with no pulses ends the digit silently
                dialing_next       = 1'b0;
                result.digit_valid = (count_next != '0);
                result.digit       = (count_next != '0) ? map_digit(count_next) : '0;
                count_next         = '0;
            end
        end
        else if (dialing_next && tmr_gt(since_restart_next, dial_timeout))
        begin
            dialing_next       = 1'b0;
            result.digit_valid = 1'b1;
            result.digit       = map_digit(count_next);
            count_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_prev_reg    <= 1'b1;
            count_reg         <= '0;
            dialing_reg       <= 1'b0;
            since_pulse_reg   <= '0;
            since_restart_reg <= '0;
            mode_last_reg     <= 1'b0;
            mode_stable_reg   <= 1'b0;
            since_mode_reg    <= '0;
        end
        else if (adv)
        begin
            pulse_prev_reg    <= pulse_level;
            count_reg         <= count_next;
            dialing_reg       <= dialing_next;
            since_pulse_reg   <= since_pulse_next;
            since_restart_reg <= since_restart_next;
            mode_last_reg     <= mode_last_next;
            mode_stable_reg   <= mode_stable_next;
            since_mode_reg    <= since_mode_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !dialing_reg |-> (count_reg == '0))
        else $error("pulse count held while not dialing");
`endif

endmodule

FILE: src/rotary_dial_hook_decoder.sv
// Rotary dial, hook switch and button decoder.
// Input channel: one word per millisecond tick carrying the sampled pulse,
// hook, button and mode pin levels; taken when in_valid is high and
// in_stall is low. Output channel: one word per input word with the digit
// (digit_valid, digit), the hook event and off-hook state, and the button
// press and pressed state; taken when out_valid is high and out_stall low.
// A word taken is registered on the input side, decoded in a single pass
// and loaded into the result register when that register is free or being
// drained; a stall on a full result register holds it in the input register.
// Throughput: one word per cycle while the output is not stalled, set by the
// single decode pass between the input register and the result register.
// A stall on the output holds the result register; the input register still
// takes a word while the result register is full, then in_stall rises.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; indexes beyond the list are dropped. Write only while idle.
// Reset clears both registers' valid flags, loads the default configuration
// and returns all debounce timers, pulse count and states to rest.
module rotary_dial_hook_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  pulse_level,
    input  logic                  hook_level,
    input  logic                  button_level,
    input  logic                  mode_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  digit_valid,
    output rdh_pkg::count_t       digit,
    output logic                  hook_event,
    output logic                  off_hook,
    output logic                  button_press,
    output logic                  button_down,
    input  logic                  cfg_we,
    input  rdh_pkg::cfg_index_t   cfg_index,
    input  rdh_pkg::cfg_t         cfg_data
);
    import rdh_pkg::*;

    cfg_t      pulse_db_reg;
    cfg_t      dial_timeout_reg;
    cfg_t      hook_db_reg;
    cfg_t      button_db_reg;
    logic      use_mode_reg;
    logic      mode_low_reg;

    logic      s1_valid_reg;
    logic      pulse_s1_reg;
    logic      hook_s1_reg;
    logic      button_s1_reg;
    logic      mode_s1_reg;

    logic      s2_valid_reg;
    logic      digit_valid_reg;
    count_t    digit_reg;
    logic      hook_event_reg;
    logic      off_hook_reg;
    logic      button_press_reg;
    logic      button_down_reg;

    logic      adv;
    logic      take;
    dial_out_t dial_res;
    deb_out_t  hook_res;
    deb_out_t  button_res;

    // advance the input word when the result register is free or being drained
    assign adv      = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_db_reg     <= PULSE_DB_RESET;
            dial_timeout_reg <= DIAL_TIMEOUT_RESET;
            hook_db_reg      <= HOOK_DB_RESET;
            button_db_reg    <= BUTTON_DB_RESET;
            use_mode_reg     <= 1'b0;
            mode_low_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PULSE_DB:     pulse_db_reg     <= cfg_data;
                CFG_DIAL_TIMEOUT: dial_timeout_reg <= cfg_data;
                CFG_HOOK_DB:      hook_db_reg      <= cfg_data;
                CFG_BUTTON_DB:    button_db_reg    <= cfg_data;
                CFG_USE_MODE:     use_mode_reg     <= cfg_data[0];
                CFG_MODE_LOW:     mode_low_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take || adv)
        begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pulse_s1_reg  <= pulse_level;
            hook_s1_reg   <= hook_level;
            button_s1_reg <= button_level;
            mode_s1_reg   <= mode_level;
        end
    end

    rdh_dial u_dial (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .pulse_level  (pulse_s1_reg),
        .mode_level   (mode_s1_reg),
        .pulse_db     (pulse_db_reg),
        .dial_timeout (dial_timeout_reg),
        .use_mode     (use_mode_reg),
        .mode_low     (mode_low_reg),
        .result       (dial_res)
    );

    rdh_debounce u_hook (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .level  (hook_s1_reg),
        .thr    (hook_db_reg),
        .result (hook_res)
    );

    // button is active low: debounce the pressed level
    rdh_debounce u_button (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .level  (!button_s1_reg),
        .thr    (button_db_reg),
        .result (button_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv || !out_stall)
        begin
            s2_valid_reg <= adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            digit_valid_reg  <= dial_res.digit_valid;
            digit_reg        <= dial_res.digit;
            hook_event_reg   <= hook_res.change;
            off_hook_reg     <= hook_res.level;
            button_press_reg <= button_res.change && button_res.level;
            button_down_reg  <= button_res.level;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign digit_valid  = digit_valid_reg;
    assign digit        = digit_reg;
    assign hook_event   = hook_event_reg;
    assign off_hook     = off_hook_reg;
    assign button_press = button_press_reg;
    assign button_down  = button_down_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && digit_valid_reg) |-> (digit_reg <= DIGIT_MAX))
        else $error("digit out of range");
    a_digit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !digit_valid_reg) |-> (digit_reg == '0))
        else $error("digit nonzero without a completed digit");
`endif

endmodule

FILE: tb/sv/dial_check_pkg.sv
`timescale 1ns / 100ps

package dial_check_pkg;

    import rdh_pkg::*;

    // indexes past the register list; writes to them must be dropped
    localparam cfg_index_t CFG_SPARE_LO = 3'd6;
    localparam cfg_index_t CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic pulse;
        logic hook;
        logic button;
        logic mode;
    } tick_t;

    typedef struct packed {
        logic   digit_valid;
        count_t digit;
        logic   hook_event;
        logic   off_hook;
        logic   button_press;
        logic   button_down;
    } dial_word_t;

    class dial_decoder_check;

        cfg_t pulse_db;
        cfg_t dial_timeout;
        cfg_t hook_db;
        cfg_t button_db;
        logic use_mode;
        logic mode_low;

        logic   pulse_prev;
        count_t pulses;
        logic   dialing;
        tmr_t   since_pulse;
        tmr_t   since_restart;
        tmr_t   since_mode;
        tmr_t   since_hook;
        tmr_t   since_button;
        logic   mode_raw;
        logic   mode_stable;
        logic   hook_raw;
        logic   hook_state;
        logic   button_raw;
        logic   button_state;

        dial_word_t awaited_words[$];

        int mismatches;
        int words_checked;
        int digits_seen;
        int hook_events;
        int presses;

        function new();
            pulse_db      = PULSE_DB_RESET;
            dial_timeout  = DIAL_TIMEOUT_RESET;
            hook_db       = HOOK_DB_RESET;
            button_db     = BUTTON_DB_RESET;
            use_mode      = 1'b0;
            mode_low      = 1'b1;
            pulse_prev    = 1'b1;
            pulses        = '0;
            dialing       = 1'b0;
            since_pulse   = '0;
            since_restart = '0;
            since_mode    = '0;
            since_hook    = '0;
            since_button  = '0;
            mode_raw      = 1'b0;
            mode_stable   = 1'b0;
            hook_raw      = 1'b0;
            hook_state    = 1'b0;
            button_raw    = 1'b1;
            button_state  = 1'b0;
            mismatches    = 0;
            words_checked = 0;
            digits_seen   = 0;
            hook_events   = 0;
            presses       = 0;
        endfunction

        function void write_reg(cfg_index_t idx, cfg_t val);
            case (idx)
                CFG_PULSE_DB:     pulse_db = val;
                CFG_DIAL_TIMEOUT: dial_timeout = val;
                CFG_HOOK_DB:      hook_db = val;
                CFG_BUTTON_DB:    button_db = val;
                CFG_USE_MODE:     use_mode = val[0];
                CFG_MODE_LOW:     mode_low = val[0];
                default:          ;
            endcase
        endfunction

        // hold at all ones rather than wrap
        function tmr_t bump(tmr_t t);
            return (t == '1) ? t : t + 1'b1;
        endfunction

        function int waiting();
            return awaited_words.size();
        endfunction

        function void take_tick(tick_t t);
            dial_word_t w;
            logic       active;
            w = '0;
            since_pulse   = bump(since_pulse);
            since_restart = bump(since_restart);
            since_mode    = bump(since_mode);
            since_hook    = bump(since_hook);
            since_button  = bump(since_button);

            if (pulse_prev && !t.pulse && since_pulse > pulse_db)
            begin
                if (pulses != COUNT_MAX)
                    pulses = pulses + 1'b1;
                since_pulse   = '0;
                since_restart = '0;
                dialing       = 1'b1;
            end
            pulse_prev = t.pulse;

            if (use_mode)
            begin
                active = (t.mode != mode_low);
                if (active != mode_raw)
                begin
                    since_mode = '0;
                    mode_raw   = active;
                end
                if (since_mode > MODE_DEBOUNCE_TICKS)
                    mode_stable = active;
                if (mode_stable)
                begin
                    dialing       = 1'b1;
                    since_restart = '0;
                end
                else if (dialing)
                begin
                    // release with no pulses ends dialing silently
                    dialing = 1'b0;
                    if (pulses != '0)
                    begin
                        w.digit_valid = 1'b1;
                        w.digit       = (pulses > DIGIT_MAX) ? '0 : pulses;
                    end
                    pulses = '0;
                end
            end
            else if (dialing && since_restart > dial_timeout)
            begin
                dialing       = 1'b0;
                w.digit_valid = 1'b1;
                w.digit       = (pulses > DIGIT_MAX) ? '0 : pulses;
                pulses        = '0;
            end

            if (t.hook != hook_raw)
            begin
                since_hook = '0;
                hook_raw   = t.hook;
            end
            if (since_hook > hook_db && t.hook != hook_state)
            begin
                hook_state   = t.hook;
                w.hook_event = 1'b1;
            end

            // button is active low
            if (t.button != button_raw)
            begin
                since_button = '0;
                button_raw   = t.button;
            end
            if (since_button > button_db && (!t.button) != button_state)
            begin
                button_state   = !t.button;
                w.button_press = !t.button;
            end

            w.off_hook    = hook_state;
            w.button_down = button_state;
            awaited_words.push_back(w);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(dial_word_t got);
            dial_word_t want;
            if (awaited_words.size() == 0)
            begin
                $error("output word with nothing awaited");
                mismatches++;
                return;
            end
            want = awaited_words.pop_front();
            words_checked++;
            digits_seen += want.digit_valid;
            hook_events += want.hook_event;
            presses     += want.button_press;
            compare_field("digit_valid", want.digit_valid, got.digit_valid);
            compare_field("digit", want.digit, got.digit);
            compare_field("hook_event", want.hook_event, got.hook_event);
            compare_field("off_hook", want.off_hook, got.off_hook);
            compare_field("button_press", want.button_press, got.button_press);
            compare_field("button_down", want.button_down, got.button_down);
        endfunction

    endclass

endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import rdh_pkg::*;
    import dial_check_pkg::*;

    localparam int   CYCLE_LIMIT   = 600000;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   SESSIONS      = 9;
    localparam int   SESSION_TICKS = 100;
    localparam cfg_t REG_MAX       = '1;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic       pulse_level  = 1'b1;
    logic       hook_level   = 1'b0;
    logic       button_level = 1'b1;
    logic       mode_level   = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic       digit_valid;
    count_t     digit;
    logic       hook_event;
    logic       off_hook;
    logic       button_press;
    logic       button_down;
    logic       cfg_we       = 1'b0;
    cfg_index_t cfg_index    = '0;
    cfg_t       cfg_data     = '0;

    dial_decoder_check decoder_check = new();

    tick_t lv;
    bit    stir_on;
    int    sender_idle_pct = 0;
    int    stall_pct       = 0;
    int    ticks_sent      = 0;
    int    settings_used   = 0;
    int    cycles          = 0;

    always #4 clk = ~clk;

    rotary_dial_hook_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pulse_level  (pulse_level),
        .hook_level   (hook_level),
        .button_level (button_level),
        .mode_level   (mode_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digit_valid  (digit_valid),
        .digit        (digit),
        .hook_event   (hook_event),
        .off_hook     (off_hook),
        .button_press (button_press),
        .button_down  (button_down),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // everything moves on the rising edge, so the falling edge sees what the next one takes
    always @(negedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            decoder_check.take_tick({pulse_level, hook_level, button_level, mode_level});
        if (rst_n && out_valid && !out_stall)
            decoder_check.check_word({digit_valid, digit, hook_event, off_hook,
                                      button_press, button_down});
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, decoder_check.waiting());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_tick();
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        pulse_level  <= lv.pulse;
        hook_level   <= lv.hook;
        button_level <= lv.button;
        mode_level   <= lv.mode;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        ticks_sent++;
    endtask

    // occasional hook and button flips; short runs between them act as bounce
    task automatic hold(int n);
        repeat (n)
        begin
            if (stir_on && $urandom_range(99) < 4)
                lv.hook = ~lv.hook;
            if (stir_on && $urandom_range(99) < 4)
                lv.button = ~lv.button;
            send_tick();
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (decoder_check.waiting() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(cfg_index_t idx, cfg_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        decoder_check.write_reg(idx, val);
    endtask

    task automatic set_regs(cfg_t pdb, cfg_t tmo, cfg_t hdb, cfg_t bdb,
                            logic use_pin, logic act_low);
        drain();
        put_reg(CFG_PULSE_DB, pdb);
        put_reg(CFG_DIAL_TIMEOUT, tmo);
        put_reg(CFG_HOOK_DB, hdb);
        put_reg(CFG_BUTTON_DB, bdb);
        // upper bits of the one-bit registers carry noise
        put_reg(CFG_USE_MODE, {15'($urandom), use_pin});
        put_reg(CFG_MODE_LOW, {15'($urandom), act_low});
        put_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, cfg_t'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic pulse_train(int n);
        int lo;
        int hi;
        int pdb;
        pdb = int'(decoder_check.pulse_db);
        repeat (n)
        begin
            lo = $urandom_range(1, 2);
            if (pdb > 16 || $urandom_range(99) < 15)
                hi = $urandom_range(1, 4);
            else
                hi = pdb + 1 - lo + $urandom_range(0, 2);
            if (hi < 1)
                hi = 1;
            lv.pulse = 1'b0;
            hold(lo);
            lv.pulse = 1'b1;
            hold(hi);
        end
    endtask

    task automatic dial_digit();
        int n;
        int tmo;
        n   = ($urandom_range(99) < 15) ? $urandom_range(10, 17) : $urandom_range(0, 9);
        tmo = int'(decoder_check.dial_timeout);
        if (decoder_check.use_mode)
        begin
            lv.mode = ~decoder_check.mode_low;
            hold(($urandom_range(99) < 15) ? $urandom_range(2, 20) : $urandom_range(22, 26));
            pulse_train(n);
            lv.mode = decoder_check.mode_low;
            hold($urandom_range(22, 26));
        end
        else
        begin
            // mode debounce is frozen here, so let the pin wander
            lv.mode = 1'($urandom_range(1));
            pulse_train(n);
            hold((tmo < 64) ? tmo + $urandom_range(1, 3) : $urandom_range(1, 20));
        end
    endtask

    initial
    begin
        int start;
        lv      = '{pulse: 1'b1, hook: 1'b0, button: 1'b1, mode: 1'b0};
        stir_on = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // bounce rejection, field extremes, timeout digit, hook and button events
        set_regs(2, 3, 0, 0, 1'b0, 1'b0);
        hold(4);
        lv.hook  = 1'b1;
        lv.mode  = 1'b1;
        hold(2);
        lv.pulse = 1'b0;
        hold(1);
        lv.pulse = 1'b1;
        hold(1);
        lv.pulse = 1'b0;
        hold(1);
        lv.pulse = 1'b1;
        hold(2);
        lv.pulse = 1'b0;
        hold(1);
        lv.pulse = 1'b1;
        hold(5);
        lv = '0;
        hold(6);
        lv.button = 1'b1;
        lv.pulse  = 1'b1;
        hold(2);

        // active mode pin leaves dialing set with no pulses; timeout then gives digit 0
        set_regs(2, 3, 0, 0, 1'b1, 1'b1);
        lv.mode = 1'b0;
        hold(23);
        set_regs(2, 3, 0, 0, 1'b0, 1'b1);
        lv.mode = 1'b1;
        hold(6);

        stir_on = 1'b1;
        for (int k = 0; k < SESSIONS; k++)
        begin
            case (k)
                0:       set_regs(0, 0, 0, 0, 1'b0, 1'b0);
                3:       set_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX, 1'b1, 1'b1);
                default: set_regs(cfg_t'($urandom_range(0, 4)), cfg_t'($urandom_range(2, 12)),
                                  cfg_t'($urandom_range(0, 8)), cfg_t'($urandom_range(0, 8)),
                                  k[0], k[1]);
            endcase
            case (k % 4)
                0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
                1:       begin sender_idle_pct = 80; stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  stall_pct = 80; end
                default: begin sender_idle_pct = 36; stall_pct = 36; end
            endcase
            start = ticks_sent;
            while (ticks_sent - start < ((k == 3) ? SESSION_TICKS / 2 : SESSION_TICKS))
                dial_digit();
        end
        drain();

        $display("%0d ticks checked over %0d register settings:",
                 decoder_check.words_checked, settings_used);
        $display("%0d digits, %0d hook events, %0d presses; both digit-end modes and polarities",
                 decoder_check.digits_seen, decoder_check.hook_events, decoder_check.presses);
        if (decoder_check.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/rdh_pkg.sv
src/rdh_debounce.sv
src/rdh_dial.sv
src/rotary_dial_hook_decoder.sv
tb/sv/dial_check_pkg.sv
tb/sv/testbench.sv
